// File: rtl/bse_pkg.sv
// Shared types and constants for the bubble sort engine.
// No dependencies; used by bubble_sort_engine and bse_cmp_unit.
`default_nettype none

package bse_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_PASS_RD0,
    S_PASS_LD,
    S_SWEEP,
    S_PASS_END,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_SEND
  } state_t;

  // Control of the shared compare/swap unit.
  typedef struct packed {
    logic load;  // take the first entry of a pass into the carry register
    logic step;  // compare carry against the next entry, keep the larger
  } cmp_ctl_t;

endpackage

`default_nettype wire

// File: rtl/bubble_sort_engine.sv
// Bubble sort engine: collects signed values, sorts ascending, streams them out.
// After the closing transfer the kept values are sorted by bubble passes; then each
// result is read from RAM, registered and offered, held while the output stalls.
// Input: one transfer per cycle while collecting; no new set is taken until the
// last result is sent. Sorting speed is set by the single compare unit on one RAM port.
// Reset (rst, synchronous): empty set, ready to collect. Uses bse_pkg, bse_ram, bse_cmp_unit.
`default_nettype none

module bubble_sort_engine #(
  parameter int unsigned MAX_ITEMS = 64  // capacity, 2..64
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic signed [bse_pkg::DATA_W-1:0]  s_axis_tdata,   // [31:0] value
  input  logic                               s_axis_tlast,   // is_last
  // Output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic signed [bse_pkg::DATA_W-1:0]  m_axis_tdata,   // [31:0] sorted_value
  output logic                               m_axis_tlast,   // is_last_res
  output logic                               m_axis_tuser    // [0] overflowed
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  bse_pkg::state_t state, state_next;

  logic [CW-1:0] count, count_next;          // values kept in this set
  logic          ovf, ovf_next;              // items dropped in this set
  logic [AW-1:0] k, k_next;                  // sweep / emit index
  logic [AW-1:0] last_idx, last_idx_next;    // top index of the current pass

  // RAM and compare unit hookup
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [bse_pkg::DATA_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [bse_pkg::DATA_W-1:0] ram_rdata;
  bse_pkg::cmp_ctl_t          cmp_ctl;
  logic [bse_pkg::DATA_W-1:0] cmp_wdata;
  logic [bse_pkg::DATA_W-1:0] cmp_carry;

  // Output payload register
  logic [bse_pkg::DATA_W-1:0] out_data;
  logic                       out_last;

  logic          in_xfer;
  logic          full;
  logic [CW-1:0] n_kept;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign full    = (count == CW'(MAX_ITEMS));
  assign n_kept  = full ? count : count + CW'(1);

  bse_ram #(
    .WIDTH (bse_pkg::DATA_W),
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bse_cmp_unit u_cmp (
    .clk   (clk),
    .ctl   (cmp_ctl),
    .rdata (ram_rdata),
    .wdata (cmp_wdata),
    .carry (cmp_carry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bse_pkg::S_COLLECT;
      count    <= '0;
      ovf      <= 1'b0;
      k        <= '0;
      last_idx <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      ovf      <= ovf_next;
      k        <= k_next;
      last_idx <= last_idx_next;
    end
  end

  // Output payload, registered from the RAM read data in S_OUT_LD.
  always_ff @(posedge clk) begin
    if (state == bse_pkg::S_OUT_LD) begin
      out_data <= ram_rdata;
      out_last <= ((CW'(k) + CW'(1)) == count);
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    ovf_next      = ovf;
    k_next        = k;
    last_idx_next = last_idx;
    ram_we        = 1'b0;
    ram_waddr     = k;
    ram_wdata     = cmp_wdata;
    ram_raddr     = '0;
    cmp_ctl       = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;

    unique case (state)
      bse_pkg::S_COLLECT: begin
        s_axis_tready = 1'b1;
        if (in_xfer) begin
          if (!full) begin
            ram_we     = 1'b1;
            ram_waddr  = count[AW-1:0];
            ram_wdata  = s_axis_tdata;
            count_next = count + CW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (s_axis_tlast) begin
            last_idx_next = AW'(n_kept - CW'(1));
            k_next        = '0;
            // a single value is already sorted
            state_next    = (n_kept == CW'(1)) ? bse_pkg::S_OUT_RD : bse_pkg::S_PASS_RD0;
          end
        end
      end
      bse_pkg::S_PASS_RD0: begin
        ram_raddr  = '0;
        state_next = bse_pkg::S_PASS_LD;
      end
      bse_pkg::S_PASS_LD: begin
        cmp_ctl.load = 1'b1;
        ram_raddr    = AW'(1);
        k_next       = '0;
        state_next   = bse_pkg::S_SWEEP;
      end
      bse_pkg::S_SWEEP: begin
        // rdata holds entry k+1; the smaller of carry/rdata settles at k
        cmp_ctl.step = 1'b1;
        ram_we       = 1'b1;
        ram_waddr    = k;
        ram_wdata    = cmp_wdata;
        if (k + AW'(1) == last_idx) begin
          state_next = bse_pkg::S_PASS_END;
        end else begin
          ram_raddr = k + AW'(2);
          k_next    = k + AW'(1);
        end
      end
      bse_pkg::S_PASS_END: begin
        // largest of the pass lands at the top
        ram_we        = 1'b1;
        ram_waddr     = last_idx;
        ram_wdata     = cmp_carry;
        last_idx_next = last_idx - AW'(1);
        k_next        = '0;
        state_next    = (last_idx == AW'(1)) ? bse_pkg::S_OUT_RD : bse_pkg::S_PASS_RD0;
      end
      bse_pkg::S_OUT_RD: begin
        ram_raddr  = k;
        state_next = bse_pkg::S_OUT_LD;
      end
      bse_pkg::S_OUT_LD: begin
        state_next = bse_pkg::S_OUT_SEND;
      end
      bse_pkg::S_OUT_SEND: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if (out_last) begin
            count_next = '0;
            ovf_next   = 1'b0;
            k_next     = '0;
            state_next = bse_pkg::S_COLLECT;
          end else begin
            k_next     = k + AW'(1);
            state_next = bse_pkg::S_OUT_RD;
          end
        end
      end
      default: begin
        state_next = bse_pkg::S_COLLECT;
      end
    endcase
  end

  assign m_axis_tdata = out_data;
  assign m_axis_tlast = out_last;
  assign m_axis_tuser = ovf;

  // Input and output sides are never open together.
  a_sides_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is offered");

  // Closing transfer stops collection.
  a_close_stops_input: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("still collecting after the closing transfer");

  // Fill count stays within capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  // Sweep index stays below the pass top.
  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bse_pkg::S_SWEEP) |-> (k < last_idx))
    else $error("sweep index past pass top");

  // Emission index stays inside the kept set.
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bse_pkg::S_OUT_SEND) |-> (CW'(k) < count))
    else $error("emitting beyond kept values");

endmodule

`default_nettype wire

// File: rtl/bse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/bse_cmp_unit.sv
// Shared compare/swap unit: carries the larger value along one bubble pass.
// Depends on bse_pkg.
`default_nettype none

module bse_cmp_unit (
  input  logic                          clk,
  input  bse_pkg::cmp_ctl_t             ctl,
  input  logic [bse_pkg::DATA_W-1:0]    rdata,   // entry k+1 during a step
  output logic [bse_pkg::DATA_W-1:0]    wdata,   // value that settles at entry k
  output logic [bse_pkg::DATA_W-1:0]    carry    // largest value seen in the pass
);

  logic gt;

  // Signed compare; equal values are not swapped.
  assign gt    = $signed(carry) > $signed(rdata);
  assign wdata = gt ? rdata : carry;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      carry <= rdata;
    end else if (ctl.step && !gt) begin
      carry <= rdata;
    end
  end

endmodule

`default_nettype wire
